### sv/spq_pkg.sv
// Shared types, widths and codes for the sorted priority queue.
package spq_pkg;

   localparam int SPQ_CAPACITY = 16;
   localparam int DATA_W       = 32;
   localparam int OCC_W        = 5;
   localparam int STATUS_W     = 2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic ins;
      logic rem;
   } cell_ctl_type;

endpackage

### sv/spq_if.sv
// Request and response channel interfaces for the sorted priority queue.
interface spq_req_if
   import spq_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic signed [DATA_W-1:0] item_value;
   logic signed [DATA_W-1:0] item_priority;

   modport source (output valid, cmd, item_value, item_priority, input ready);
   modport sink   (input valid, cmd, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if
   import spq_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] out_value;
   logic signed [DATA_W-1:0] out_priority;
   logic [STATUS_W-1:0]      status;
   logic [OCC_W-1:0]         occupancy;

   modport source (output valid, out_value, out_priority, status, occupancy, input ready);
   modport sink   (input valid, out_value, out_priority, status, occupancy, output ready);
endinterface

### sv/sorted_priority_queue_core.sv
// Sorted priority queue built as a chain of shifting slots.
// A result word appears in the cycle after its request word is accepted.
// One word per cycle unless the output stalls; all slots compare and shift at once.
// Reset clears the entry count and the response valid; slot contents are left as is.
module sorted_priority_queue_core
   import spq_pkg::*;
#(
   parameter int CAPACITY = SPQ_CAPACITY
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_bus,
   spq_rsp_if.source rsp_bus
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic signed [DATA_W-1:0] rsp_prio_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [OCC_W-1:0]         rsp_occ_ff;

   logic                     accept;
   logic                     full;
   logic                     empty;
   cell_ctl_type             ctl;
   entry_type                new_ent;
   entry_type                ents [CAPACITY];
   logic [CAPACITY-1:0]      gts;
   logic [STATUS_W-1:0]      status;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign full          = (count_ff == CW'(CAPACITY));
   assign empty         = (count_ff == '0);
   assign ctl.ins       = accept && (req_bus.cmd == CMD_INSERT) && !full;
   assign ctl.rem       = accept && (req_bus.cmd == CMD_REMOVE) && !empty;
   assign new_ent.value = req_bus.item_value;
   assign new_ent.prio  = req_bus.item_priority;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      spq_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .valid     (CW'(i) < count_ff),
         .prev_gt   ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i - 1]),
         .new_ent   (new_ent),
         .left_ent  (ents[(i == 0) ? 0 : i - 1]),
         .right_ent (ents[(i == CAPACITY - 1) ? i : i + 1]),
         .ent       (ents[i]),
         .gt        (gts[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      status   = STATUS_OK;
      if (ctl.ins) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.rem) begin
         count_in = count_ff - 1'b1;
      end
      if (req_bus.cmd == CMD_INSERT && full) begin
         status = STATUS_OVERFLOW;
      end else if (req_bus.cmd == CMD_REMOVE && empty) begin
         status = STATUS_UNDERFLOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff  <= ctl.rem ? ents[0].value : '0;
         rsp_prio_ff   <= ctl.rem ? ents[0].prio : '0;
         rsp_status_ff <= status;
         rsp_occ_ff    <= OCC_W'(count_in);
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_value    = rsp_value_ff;
   assign rsp_bus.out_priority = rsp_prio_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.occupancy    = rsp_occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ctl.ins |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the queue");

   a_underflow: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.cmd == CMD_REMOVE && empty |=>
         rsp_status_ff == STATUS_UNDERFLOW && rsp_value_ff == '0 && count_ff == '0)
      else $error("empty remove not reported as underflow");

   a_sorted_front: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(2) |-> ents[0].prio <= ents[1].prio)
      else $error("front entries out of order");

endmodule

### sv/spq_cell.sv
// One queue slot: holds an entry and shifts with its neighbors on insert or remove.
module spq_cell
   import spq_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         valid,
   input  logic         prev_gt,
   input  entry_type    new_ent,
   input  entry_type    left_ent,
   input  entry_type    right_ent,
   output entry_type    ent,
   output logic         gt
);

   entry_type ent_ff;
   entry_type ent_in;

   // new entry belongs at or before this slot
   assign gt  = !valid || (ent_ff.prio > new_ent.prio);
   assign ent = ent_ff;

   always_comb begin
      ent_in = ent_ff;
      if (ctl.ins && gt) begin
         ent_in = prev_gt ? left_ent : new_ent;
      end else if (ctl.rem) begin
         ent_in = right_ent;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule

### test/sorted_priority_queue_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sorted priority queue core: directed table, then random words.
module sorted_priority_queue_core_tb;
   import spq_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 1000;
   localparam int N_DIRECTED   = 22;

   localparam logic signed [DATA_W-1:0] PRIO_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] PRIO_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
      logic [STATUS_W-1:0]      status;
      logic [OCC_W-1:0]         occupancy;
   } rsp_word_type;

   typedef struct packed {
      logic                     cmd;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
      logic                     typed;
      rsp_word_type             expected;
   } stim_row_type;

   // typed = 1: expected word is taken from the row, else from the queue model
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{CMD_REMOVE, -32'sd1, -32'sd1, 1'b1, '{32'sd0, 32'sd0, STATUS_UNDERFLOW, 5'd0}},
      '{CMD_INSERT, PRIO_MAX, PRIO_MAX, 1'b1, '{32'sd0, 32'sd0, STATUS_OK, 5'd1}},
      '{CMD_INSERT, PRIO_MIN, PRIO_MIN, 1'b1, '{32'sd0, 32'sd0, STATUS_OK, 5'd2}},
      '{CMD_INSERT, 32'sd5, 32'sd0, 1'b1, '{32'sd0, 32'sd0, STATUS_OK, 5'd3}},
      '{CMD_INSERT, 32'sd6, 32'sd0, 1'b1, '{32'sd0, 32'sd0, STATUS_OK, 5'd4}},
      '{CMD_INSERT, -32'sd1, -32'sd1, 1'b1, '{32'sd0, 32'sd0, STATUS_OK, 5'd5}},
      '{CMD_INSERT, 32'sd7, PRIO_MAX, 1'b1, '{32'sd0, 32'sd0, STATUS_OK, 5'd6}},
      '{CMD_INSERT, 32'sd8, PRIO_MIN, 1'b1, '{32'sd0, 32'sd0, STATUS_OK, 5'd7}},
      '{CMD_INSERT, 32'sd9, 32'sd1, 1'b1, '{32'sd0, 32'sd0, STATUS_OK, 5'd8}},
      '{CMD_INSERT, 32'sd10, -32'sd2, 1'b1, '{32'sd0, 32'sd0, STATUS_OK, 5'd9}},
      '{CMD_INSERT, 32'sd11, 32'sd0, 1'b1, '{32'sd0, 32'sd0, STATUS_OK, 5'd10}},
      '{CMD_INSERT, 32'sd12, 32'sh4000_0000, 1'b1, '{32'sd0, 32'sd0, STATUS_OK, 5'd11}},
      '{CMD_INSERT, 32'sd13, 32'shC000_0000, 1'b1, '{32'sd0, 32'sd0, STATUS_OK, 5'd12}},
      '{CMD_INSERT, 32'sd14, -32'sd1, 1'b1, '{32'sd0, 32'sd0, STATUS_OK, 5'd13}},
      '{CMD_INSERT, 32'sd15, 32'sd2, 1'b1, '{32'sd0, 32'sd0, STATUS_OK, 5'd14}},
      '{CMD_INSERT, 32'sd16, 32'sd1, 1'b1, '{32'sd0, 32'sd0, STATUS_OK, 5'd15}},
      '{CMD_INSERT, 32'sd17, 32'sd0, 1'b1, '{32'sd0, 32'sd0, STATUS_OK, 5'd16}},
      '{CMD_INSERT, 32'sd18, 32'sd0, 1'b1, '{32'sd0, 32'sd0, STATUS_OVERFLOW, 5'd16}},
      '{CMD_REMOVE, 32'sh5A5A_5A5A, 32'sh1234_5678, 1'b1,
        '{PRIO_MIN, PRIO_MIN, STATUS_OK, 5'd15}},
      '{CMD_REMOVE, 32'sd0, 32'sd0, 1'b1, '{32'sd8, PRIO_MIN, STATUS_OK, 5'd14}},
      '{CMD_REMOVE, -32'sd1, PRIO_MAX, 1'b0, '0},
      '{CMD_INSERT, 32'sd19, PRIO_MIN, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   sorted_priority_queue_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #2 clock = ~clock;

   // queue model
   logic signed [DATA_W-1:0] slot_val [SPQ_CAPACITY];
   logic signed [DATA_W-1:0] slot_pri [SPQ_CAPACITY];
   int                       stored = 0;

   rsp_word_type results_due [$];
   int           error_count = 0;
   int           cycle_count = 0;
   logic         steady;
   logic         word_typed;
   rsp_word_type word_expected;

   function automatic rsp_word_type serve_word(logic cmd, logic signed [DATA_W-1:0] value,
                                               logic signed [DATA_W-1:0] prio);
      rsp_word_type r;
      int           pos;
      r = '0;
      if (cmd == CMD_INSERT) begin
         if (stored >= SPQ_CAPACITY) begin
            r.status = STATUS_OVERFLOW;
         end else begin
            pos = 0;
            while (pos < stored && slot_pri[pos] <= prio) pos++;
            for (int i = stored; i > pos; i--) begin
               slot_val[i] = slot_val[i-1];
               slot_pri[i] = slot_pri[i-1];
            end
            slot_val[pos] = value;
            slot_pri[pos] = prio;
            stored++;
         end
      end else if (stored == 0) begin
         r.status = STATUS_UNDERFLOW;
      end else begin
         r.value = slot_val[0];
         r.prio  = slot_pri[0];
         for (int i = 1; i < stored; i++) begin
            slot_val[i-1] = slot_val[i];
            slot_pri[i-1] = slot_pri[i];
         end
         stored--;
      end
      r.occupancy = stored[OCC_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_word_type got, due, model;
      if (!reset && req_bus.valid && req_bus.ready) begin
         model = serve_word(req_bus.cmd, req_bus.item_value, req_bus.item_priority);
         results_due.push_back(word_typed ? word_expected : model);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.out_value, rsp_bus.out_priority, rsp_bus.status, rsp_bus.occupancy};
         if (results_due.size() == 0) begin
            $display("%0t: unexpected word, value %0d priority %0d status %0d occupancy %0d",
                     $time, got.value, got.prio, got.status, got.occupancy);
            error_count++;
         end else begin
            due = results_due.pop_front();
            if (got.value !== due.value) begin
               $display("%0t: out_value expected %0d actual %0d", $time, due.value, got.value);
               error_count++;
            end
            if (got.prio !== due.prio) begin
               $display("%0t: out_priority expected %0d actual %0d", $time, due.prio, got.prio);
               error_count++;
            end
            if (got.status !== due.status) begin
               $display("%0t: status expected %0d actual %0d", $time, due.status, got.status);
               error_count++;
            end
            if (got.occupancy !== due.occupancy) begin
               $display("%0t: occupancy expected %0d actual %0d",
                        $time, due.occupancy, got.occupancy);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 33);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_word(logic cmd, logic signed [DATA_W-1:0] value,
                            logic signed [DATA_W-1:0] prio, logic typed,
                            rsp_word_type expected);
      while (!steady && $urandom_range(99) < 33) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.cmd           <= cmd;
      req_bus.item_value    <= value;
      req_bus.item_priority <= prio;
      word_typed            <= typed;
      word_expected         <= expected;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   initial begin
      logic                     cmd;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
      int                       ins_pct;
      int                       pick;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.cmd           = CMD_INSERT;
      req_bus.item_value    = '0;
      req_bus.item_priority = '0;
      rsp_bus.ready         = 1'b0;
      steady                = 1'b0;
      word_typed            = 1'b0;
      word_expected         = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < N_DIRECTED; n++) begin
         send_word(directed_rows[n].cmd, directed_rows[n].value, directed_rows[n].prio,
                   directed_rows[n].typed, directed_rows[n].expected);
      end

      // phases swing the queue between full and empty
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         steady <= (n >= 400 && n < 600);
         case ((n / 100) % 4)
            0: ins_pct = 75;
            1: ins_pct = 25;
            2: ins_pct = 50;
            default: ins_pct = 90;
         endcase
         cmd  = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
         pick = $urandom_range(99);
         if (pick < 60) begin
            prio = $signed($urandom_range(6)) - 3;
         end else if (pick < 85) begin
            prio = $urandom;
         end else begin
            case ($urandom_range(3))
               0: prio = PRIO_MIN;
               1: prio = PRIO_MAX;
               2: prio = '0;
               default: prio = -32'sd1;
            endcase
         end
         value = $urandom;
         send_word(cmd, value, prio, 1'b0, '0);
      end
      req_bus.valid <= 1'b0;

      while (results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
